/* design/dlc_pkg.sv */
// ---------------------------------------------------------------------------
// dlc_pkg - day light curve shared definitions
// Widths, curve breakpoints, register indexes and the request handed to the
// serial multiply/divide unit.
// ---------------------------------------------------------------------------
package dlc_pkg;

  localparam int TIME_W    = 12;
  localparam int DUTY_W    = 8;
  localparam int K_W       = 8;
  localparam int PROD_W    = TIME_W + K_W;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 3;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(K_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_SUNRISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SUNSET  = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0] SUNRISE_RST = TIME_W'(600);
  localparam logic [TIME_W-1:0] SUNSET_RST  = TIME_W'(2000);
  localparam logic [TIME_W-1:0] NO_TICK     = TIME_W'(4095);

  localparam logic [TIME_W-1:0] T_0800 = TIME_W'(800);
  localparam logic [TIME_W-1:0] T_0900 = TIME_W'(900);
  localparam logic [TIME_W-1:0] T_1200 = TIME_W'(1200);
  localparam logic [TIME_W-1:0] T_1400 = TIME_W'(1400);
  localparam logic [TIME_W-1:0] T_1500 = TIME_W'(1500);
  localparam logic [TIME_W-1:0] T_ZERO = TIME_W'(0);
  localparam logic [TIME_W-1:0] T_ONE  = TIME_W'(1);

  localparam logic [DUTY_W-1:0] DUTY_OFF  = DUTY_W'(0);
  localparam logic [DUTY_W-1:0] DUTY_MIN  = DUTY_W'(1);
  localparam logic [DUTY_W-1:0] DUTY_MID  = DUTY_W'(127);
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(255);

  localparam logic [K_W-1:0] K_NONE = K_W'(0);
  localparam logic [K_W-1:0] K_127  = K_W'(127);
  localparam logic [K_W-1:0] K_128  = K_W'(128);
  localparam logic [K_W-1:0] K_254  = K_W'(254);
  localparam logic [K_W-1:0] K_255  = K_W'(255);

  // one channel: floor(d * k / den), den never zero, quotient below 256
  typedef struct packed {
    logic [TIME_W-1:0] d;
    logic [K_W-1:0]    k;
    logic [TIME_W-1:0] den;
  } dlc_req_t;

endpackage

/* design/dlc_serial_muldiv.sv */
// ---------------------------------------------------------------------------
// dlc_serial_muldiv - bit-serial scaled quotient
// Shift-add multiply over the bits of k, then restoring divide producing one
// quotient bit per cycle.
// ---------------------------------------------------------------------------
module dlc_serial_muldiv
  import dlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dlc_req_t          req,
  output logic              done,
  output logic [DUTY_W-1:0] q
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]        phase;
  logic [STEP_W-1:0] cnt;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] acc_next;
  logic [K_W-1:0]    kreg;
  logic [TIME_W-1:0] dreg;
  logic [TIME_W-1:0] den;
  logic [TIME_W-1:0] rem;
  logic [TIME_W:0]   trial;
  logic              ge;

  assign acc_next = {acc[PROD_W-2:0], 1'b0} + (kreg[K_W-1] ? PROD_W'(dreg) : PROD_W'(0));
  assign trial    = {rem, acc[DUTY_W-1]};
  assign ge       = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      // pulse on the last quotient bit
      done <= (phase == PH_DIV) && (cnt == LAST_STEP);
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_MUL;
            cnt   <= '0;
            acc   <= '0;
            kreg  <= req.k;
            dreg  <= req.d;
            den   <= req.den;
          end
        end
        PH_MUL: begin
          acc  <= acc_next;
          kreg <= {kreg[K_W-2:0], 1'b0};
          cnt  <= cnt + STEP_W'(1);              // wraps to zero after the last step
          if (cnt == LAST_STEP) begin
            // upper product bits are already below den
            rem   <= acc_next[PROD_W-1:DUTY_W];
            phase <= PH_DIV;
          end
        end
        PH_DIV: begin
          rem <= ge ? TIME_W'(trial - {1'b0, den}) : trial[TIME_W-1:0];
          q   <= {q[DUTY_W-2:0], ge};
          acc <= {acc[PROD_W-2:0], 1'b0};
          cnt <= cnt + STEP_W'(1);
          if (cnt == LAST_STEP) begin
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

/* design/day_light_curve_generator_core.sv */
// ---------------------------------------------------------------------------
// day_light_curve_generator_core - warm/cool LED duty from time of day
// Maps an HHMM tick onto a piecewise-linear day curve with configurable
// sunrise and sunset; emits a duty pair only when the tick changes.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: current_time [11:0]
//  m_*     | out | m_tvalid/m_tready  | m_tdata: warm_duty [7:0], cool_duty
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index (0 sunrise, 1 sunset),
//          |     |                    | cfg_data [11:0]
//
//  A request passes from acceptance to the result register through the
//  decode state, two passes of the shared bit-serial multiply/divide unit
//  (warm, then cool) and the write-back state. A repeated tick retires in
//  the decode state with no result. One request is in flight at a time.
//  rst is synchronous; it restores sunrise 600, sunset 2000, no tick seen and
//  dark duties. A result waiting on m_tready does not block the next request;
//  write-back waits until the output register is free.
//
module day_light_curve_generator_core
  import dlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input ticks
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [11:0] current_time, [15:12] zero
  // duty results
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [7:0] warm_duty, [15:8] cool_duty
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_WARM = 3'd2;
  localparam logic [2:0] ST_COOL = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state;
  logic [TIME_W-1:0] sunrise;
  logic [TIME_W-1:0] sunset;
  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] cur_time;
  logic [DUTY_W-1:0] warm_level;
  logic [DUTY_W-1:0] cool_level;
  logic [DUTY_W-1:0] warm_new;
  logic [DUTY_W-1:0] cool_new;

  // per-request plan: duty = base +/- floor(d * k / den)
  logic              warm_add;
  logic [DUTY_W-1:0] warm_base;
  logic              cool_add;
  logic [DUTY_W-1:0] cool_base;
  logic [K_W-1:0]    cool_k;

  dlc_req_t          req;
  logic              unit_start;
  logic              unit_done;
  logic [DUTY_W-1:0] unit_q;

  // decode outputs
  logic [TIME_W-1:0] seg_a;
  logic [TIME_W-1:0] seg_hi;
  logic [TIME_W-1:0] seg_lo;
  logic              wa;
  logic [DUTY_W-1:0] wb;
  logic [K_W-1:0]    wk;
  logic              ca;
  logic [DUTY_W-1:0] cb;
  logic [K_W-1:0]    ck;
  logic [DUTY_W-1:0] q_applied;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Segment decode, in curve priority order. Constant outputs use k = 0 and
  // a divisor of one so the serial unit returns zero.
  always_comb begin
    seg_a  = T_ZERO;
    seg_hi = T_ONE;
    seg_lo = T_ZERO;
    wa = 1'b1;  wb = warm_level;  wk = K_NONE;
    ca = 1'b1;  cb = cool_level;  ck = K_NONE;
    if (cur_time < sunrise || cur_time > sunset) begin
      wb = DUTY_OFF;  cb = DUTY_OFF;
    end else if (cur_time == sunrise || cur_time == sunset) begin
      wb = DUTY_MIN;  cb = DUTY_OFF;
    end else if (cur_time == T_1200) begin
      wb = DUTY_OFF;  cb = DUTY_FULL;
    end else if (cur_time > sunrise && cur_time < T_0800) begin
      seg_a = sunrise;  seg_hi = T_0800;  seg_lo = sunrise;
      wb = DUTY_MIN;  wk = K_254;
      cb = DUTY_OFF;
    end else if (cur_time > T_0800 && cur_time < T_0900) begin
      seg_a = T_0800;  seg_hi = T_0900;  seg_lo = T_0800;
      wb = DUTY_FULL;  wa = 1'b0;  wk = K_128;
      cb = DUTY_OFF;   ck = K_127;
    end else if (cur_time > T_0900 && cur_time < T_1200) begin
      seg_a = T_0900;  seg_hi = T_1200;  seg_lo = T_0900;
      wb = DUTY_MID;  wa = 1'b0;  wk = K_127;
      cb = DUTY_MID;  ck = K_128;
    end else if (cur_time > T_1200 && cur_time < T_1400) begin
      // this segment spans 1200..1500
      seg_a = T_1200;  seg_hi = T_1500;  seg_lo = T_1200;
      wb = DUTY_OFF;   wk = K_127;
      cb = DUTY_FULL;  ca = 1'b0;  ck = K_128;
    end else if (cur_time > T_1400 && cur_time < T_1500) begin
      seg_a = T_1400;  seg_hi = T_1500;  seg_lo = T_1400;
      wb = DUTY_MID;  wk = K_128;
      cb = DUTY_MID;  ca = 1'b0;  ck = K_127;
    end else if (cur_time > T_1500 && cur_time < sunset) begin
      seg_a = T_1500;  seg_hi = sunset;  seg_lo = T_1500;
      wb = DUTY_FULL;  wa = 1'b0;  wk = K_255;
      cb = DUTY_OFF;
    end else if (cur_time == T_0900 || cur_time == T_1500) begin
      wb = DUTY_MID;  cb = DUTY_MID;
    end
    // otherwise (800, 1400 in daylight) the held levels pass through
  end

  assign q_applied = (state == ST_WARM) ?
                     (warm_add ? warm_base + unit_q : warm_base - unit_q) :
                     (cool_add ? cool_base + unit_q : cool_base - unit_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_start <= 1'b0;
      state      <= ST_IDLE;
      sunrise    <= SUNRISE_RST;
      sunset     <= SUNSET_RST;
      last_time  <= NO_TICK;
      warm_level <= DUTY_OFF;
      cool_level <= DUTY_OFF;
      m_tvalid   <= 1'b0;
    end else begin
      // kick the serial unit for the warm pass, then again for the cool pass
      unit_start <= (state == ST_DEC && cur_time != last_time) ||
                    (state == ST_WARM && unit_done);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SUNRISE: sunrise <= cfg_data;
          REG_SUNSET:  sunset  <= cfg_data;
          default: ;
        endcase
      end

      // write-back in ST_FIN refills the register itself
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_time <= s_tdata[TIME_W-1:0];
            state    <= ST_DEC;
          end
        end
        ST_DEC: begin
          last_time <= cur_time;
          if (cur_time == last_time) begin
            state <= ST_IDLE;                  // repeated tick: no result
          end else begin
            warm_add   <= wa;
            warm_base  <= wb;
            cool_add   <= ca;
            cool_base  <= cb;
            cool_k     <= ck;
            req.d      <= cur_time - seg_a;
            req.den    <= seg_hi - seg_lo;
            req.k      <= wk;
            state      <= ST_WARM;
          end
        end
        ST_WARM: begin
          if (unit_done) begin
            warm_new   <= q_applied;
            req.k      <= cool_k;
            state      <= ST_COOL;
          end
        end
        ST_COOL: begin
          if (unit_done) begin
            cool_new <= q_applied;
            state    <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata    <= {cool_new, warm_new};
            m_tvalid   <= 1'b1;
            warm_level <= warm_new;
            cool_level <= cool_new;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  dlc_serial_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .req   (req),
    .done  (unit_done),
    .q     (unit_q)
  );

endmodule

/* design/dlc_checker.sv */
// ---------------------------------------------------------------------------
// dlc_checker - port-level checks for the day light curve core
// Watches the stream ports of the top level over time.
// ---------------------------------------------------------------------------
module dlc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request in flight: busy right after an accepted tick
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second tick accepted while first in flight");

  // a new result is only written back while input side is busy
  a_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a request in flight");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind day_light_curve_generator_core dlc_checker u_dlc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top - day light curve generator core testbench
// Streams HHMM ticks into the core across a set of sunrise/sunset settings
// and checks every warm/cool duty pair against an in-bench curve predictor.
// Both stream sides idle and stall at random; register writes happen only
// once the core has drained.
// ---------------------------------------------------------------------------
module tb_top;
  import dlc_pkg::*;

  localparam int LATENCY      = 38;      // acceptance to result register
  localparam int LIMIT_CYCLES = 600000;
  localparam int IDLE_PCT     = 20;
  localparam int PHASE_ITEMS  = 123;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;   // [11:0] current_time, [15:12] zero
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [15:0]          m_tdata;          // [7:0] warm_duty, [15:8] cool_duty
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SUNRISE;
  logic [TIME_W-1:0]    cfg_data  = '0;

  // curve predictor state: registers, last tick and last driven duties
  logic [TIME_W-1:0] sunrise_q;
  logic [TIME_W-1:0] sunset_q;
  logic [TIME_W-1:0] prev_tick;
  logic [DUTY_W-1:0] warm_q;
  logic [DUTY_W-1:0] cool_q;

  logic [15:0]       pending_duties[$];   // {cool, warm} per expected result
  logic [TIME_W-1:0] last_sent = '0;
  bit                steady = 1'b0;       // no idling on either side while set
  int                fail_count = 0;
  int                cycle_count = 0;

  day_light_curve_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Curve predictor
  // ---------------------------------------------------------------------

  // linear segment, division truncates toward zero, result saturates
  function automatic logic [DUTY_W-1:0] ramp(input int t, input int in_a,
                                             input int in_b, input int out_a,
                                             input int out_b);
    int span;
    int v;
    span = in_b - in_a;
    if (span == 0) v = out_a;
    else v = (t - in_a) * (out_b - out_a) / span + out_a;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return DUTY_W'(v);
  endfunction

  task automatic reset_curve();
    sunrise_q = SUNRISE_RST;
    sunset_q  = SUNSET_RST;
    prev_tick = NO_TICK;
    warm_q    = DUTY_OFF;
    cool_q    = DUTY_OFF;
  endtask

  // one accepted tick; queues the duty pair it produces, if any
  task automatic advance_curve(input logic [TIME_W-1:0] tick);
    int t;
    int sr;
    int ss;
    t  = int'(tick);
    sr = int'(sunrise_q);
    ss = int'(sunset_q);
    if (tick == prev_tick) return;      // repeated tick: silent, no change
    if (t < sr || t > ss) begin
      warm_q = DUTY_OFF; cool_q = DUTY_OFF;
    end else if (t == sr || t == ss) begin
      warm_q = DUTY_MIN; cool_q = DUTY_OFF;
    end else if (t == 1200) begin
      warm_q = DUTY_OFF; cool_q = DUTY_FULL;
    end else if (t > sr && t < 800) begin
      warm_q = ramp(t, sr, 800, 1, 255);
      cool_q = DUTY_OFF;
    end else if (t > 800 && t < 900) begin
      warm_q = ramp(t, 800, 900, 255, 127);
      cool_q = ramp(t, 800, 900, 0, 127);
    end else if (t > 900 && t < 1200) begin
      warm_q = ramp(t, 900, 1200, 127, 0);
      cool_q = ramp(t, 900, 1200, 127, 255);
    end else if (t > 1200 && t < 1400) begin
      // segment spans 1200..1500 even though it stops at 1400
      warm_q = ramp(t, 1200, 1500, 0, 127);
      cool_q = ramp(t, 1200, 1500, 255, 127);
    end else if (t > 1400 && t < 1500) begin
      warm_q = ramp(t, 1400, 1500, 127, 255);
      cool_q = ramp(t, 1400, 1500, 127, 0);
    end else if (t > 1500 && t < ss) begin
      warm_q = ramp(t, 1500, ss, 255, 0);
      cool_q = DUTY_OFF;
    end else if (t == 900 || t == 1500) begin
      warm_q = DUTY_MID; cool_q = DUTY_MID;
    end
    // anything else (800, 1400 in daylight) holds the previous duties
    prev_tick = tick;
    pending_duties.push_back({cool_q, warm_q});
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls, in-order compare
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_duties.size() == 0) begin
        $display("%0t unexpected result: expected none, got warm %0d cool %0d",
                 $time, m_tdata[7:0], m_tdata[15:8]);
        fail_count++;
      end else begin
        want = pending_duties.pop_front();
        if (m_tdata[7:0] !== want[7:0]) begin
          $display("%0t warm_duty mismatch: expected %0d, got %0d",
                   $time, want[7:0], m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[15:8] !== want[15:8]) begin
          $display("%0t cool_duty mismatch: expected %0d, got %0d",
                   $time, want[15:8], m_tdata[15:8]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Starts on the next falling edge, returns at the accepting rising edge with
  // tvalid still high; drain, or an idle gap before the next request, lowers it.
  task automatic send_tick(input logic [TIME_W-1:0] tick);
    int gap;
    @(negedge clk);
    gap = 0;
    if (!steady) begin
      // now and then a long gap so the request lands mid-computation
      if ($urandom_range(99) < 10) gap = $urandom_range(45, 1);
      while (gap > 0 || $urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        if (gap > 0) gap--;
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, tick};
    do @(posedge clk); while (!s_tready);
    advance_curve(tick);
    last_sent = tick;
  endtask

  // hold off until every result is out, then cover a silent repeat in flight
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [TIME_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SUNRISE) sunrise_q = value;
    else if (idx == REG_SUNSET) sunset_q = value;
  endtask

  task automatic set_day(input logic [TIME_W-1:0] sr, input logic [TIME_W-1:0] ss);
    drain();
    write_reg(REG_SUNRISE, sr);
    write_reg(REG_SUNSET, ss);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // tick mix: clock-shaped times, breakpoint neighbors, repeats, raw 12 bits, 0..2359
  function automatic logic [TIME_W-1:0] pick_tick();
    int roll;
    int base;
    roll = $urandom_range(99);
    if (roll < 40) return TIME_W'($urandom_range(23) * 100 + $urandom_range(59));
    if (roll < 60) begin
      case ($urandom_range(6))
        0: base = sunrise_q;
        1: base = sunset_q;
        2: base = T_0800;
        3: base = T_0900;
        4: base = T_1200;
        5: base = T_1400;
        default: base = T_1500;
      endcase
      return TIME_W'(base + $urandom_range(4) - 2);
    end
    if (roll < 70) return last_sent;
    if (roll < 85) return TIME_W'($urandom_range(4095));
    return TIME_W'($urandom_range(2359));
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // no-tick marker counts as a repeat on the first request; plain repeats
  task automatic test_repeat_ticks();
    send_tick(NO_TICK);
    send_tick(NO_TICK);
    send_tick(T_ZERO);
    send_tick(T_ZERO);
    send_tick(TIME_W'(2359));
  endtask

  // every segment edge under reset settings, 800 and 1400 hold
  task automatic test_breakpoints();
    int pts[21] = '{599, 600, 601, 799, 800, 801, 899, 900, 901, 1199, 1200, 1201,
                    1399, 1400, 1401, 1499, 1500, 1501, 1999, 2000, 2001};
    foreach (pts[i]) send_tick(TIME_W'(pts[i]));
  endtask

  task automatic run_ticks(input int count);
    repeat (count) send_tick(pick_tick());
  endtask

  // sweep of settings: extremes, reversed, equal, narrow and random days
  task automatic test_day_settings();
    set_day(T_ZERO, NO_TICK);              run_ticks(PHASE_ITEMS);
    set_day(NO_TICK, T_ZERO);              run_ticks(PHASE_ITEMS);
    set_day(TIME_W'(1300), TIME_W'(1300)); run_ticks(PHASE_ITEMS);
    set_day(TIME_W'(799), TIME_W'(1501));  run_ticks(PHASE_ITEMS);
    set_day(T_0800, T_1500);               run_ticks(PHASE_ITEMS);
    set_day(TIME_W'(1000), TIME_W'(1350)); run_ticks(PHASE_ITEMS);
    steady = 1'b1;                          // long stretch with no idling
    set_day(SUNRISE_RST, SUNSET_RST);      run_ticks(PHASE_ITEMS);
    steady = 1'b0;
    repeat (3) begin
      set_day(TIME_W'($urandom_range(1000)), TIME_W'($urandom_range(4095, 1400)));
      run_ticks(PHASE_ITEMS);
    end
  endtask

  initial begin
    reset_curve();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_repeat_ticks();
    test_breakpoints();
    test_day_settings();

    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
